>>> sv/fdmm_pkg.sv
// Package for the frame difference motion mask pixel block.
// Holds mode and register codes, stage payload types and shared helpers.
// No dependencies; compiled first.
`default_nettype none

package fdmm_pkg;

    // Motion mode codes
    localparam logic [1:0] MODE_HARD_COLOR  = 2'd0;
    localparam logic [1:0] MODE_HARD_NORMAL = 2'd1;
    localparam logic [1:0] MODE_SOFT_NORMAL = 2'd2;
    localparam logic [1:0] MODE_SOFT_COLOR  = 2'd3;

    // Configuration register indexes
    localparam int unsigned CFG_IDX_W = 3;
    localparam int unsigned CFG_DATA_W = 8;
    localparam logic [CFG_IDX_W-1:0] REG_MODE       = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_DIFF_THR   = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_LUMA_THR   = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_TINT_RED   = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_TINT_GREEN = 3'd4;
    localparam logic [CFG_IDX_W-1:0] REG_TINT_BLUE  = 3'd5;

    localparam logic [7:0] ALPHA_FULL = 8'd255;

    typedef struct packed {
        logic [1:0] mode;
        logic [7:0] diff_thr;
        logic [7:0] luma_thr;
        logic [7:0] tint_red;
        logic [7:0] tint_green;
        logic [7:0] tint_blue;
    } cfg_t;

    // Squared distance plus the current pixel, after the front stages
    typedef struct packed {
        logic [17:0] dist_sq;
        logic [7:0]  cur_red;
        logic [7:0]  cur_green;
        logic [7:0]  cur_blue;
        logic        luma_ok;
    } dist_t;

    // Partial root and remainder between root stages
    typedef struct packed {
        logic [17:0] rem;
        logic [7:0]  root;
    } root_t;

    // Motion strength plus the current pixel, after the root stages
    typedef struct packed {
        logic [7:0] strength;
        logic [7:0] cur_red;
        logic [7:0] cur_green;
        logic [7:0] cur_blue;
        logic       luma_ok;
    } strength_t;

    function automatic logic [7:0] abs_diff8(input logic [7:0] a, input logic [7:0] b);
        return (a > b) ? (a - b) : (b - a);
    endfunction

    // One digit of the root of dist/3: keep bit if 3*(k|bit)^2 still fits.
    // 3*(k|bit)^2 - 3*k^2 = 3*((k << (i+1)) + 4^i), taken from the remainder.
    function automatic root_t root_step(input root_t st, input logic [2:0] bit_idx);
        logic [19:0] trial;
        logic [19:0] trial3;
        root_t       res;
        trial  = ({12'd0, st.root} << ({1'b0, bit_idx} + 4'd1))
                 + (20'd1 << {bit_idx, 1'b0});
        trial3 = trial + (trial << 1);
        res    = st;
        if (trial3 <= {2'b00, st.rem})
        begin
            res.rem  = st.rem - trial3[17:0];
            res.root = st.root | (8'd1 << bit_idx);
        end
        return res;
    endfunction

endpackage

`default_nettype wire

>>> sv/fdmm_if.sv
// Stream interfaces of the motion mask block: pixel pair in, mask pixel out.
// Depends on nothing; valid/ready handshake with source and sink modports.
`default_nettype none

interface fdmm_pix_if;
    logic       valid;
    logic       ready;
    logic [7:0] prev_red;
    logic [7:0] prev_green;
    logic [7:0] prev_blue;
    logic [7:0] cur_red;
    logic [7:0] cur_green;
    logic [7:0] cur_blue;

    modport source (
        output valid, prev_red, prev_green, prev_blue, cur_red, cur_green, cur_blue,
        input  ready
    );
    modport sink (
        input  valid, prev_red, prev_green, prev_blue, cur_red, cur_green, cur_blue,
        output ready
    );
endinterface

interface fdmm_mask_if;
    logic       valid;
    logic       ready;
    logic [7:0] out_red;
    logic [7:0] out_green;
    logic [7:0] out_blue;
    logic [7:0] out_alpha;

    modport source (
        output valid, out_red, out_green, out_blue, out_alpha,
        input  ready
    );
    modport sink (
        input  valid, out_red, out_green, out_blue, out_alpha,
        output ready
    );
endinterface

`default_nettype wire

>>> sv/fdmm_front.sv
// Front stages: channel differences and gray check, then squared distance.
// Depends on fdmm_pkg and fdmm_pix_if.
`default_nettype none

module fdmm_front
    import fdmm_pkg::*;
(
    input  wire logic  clk,
    input  wire logic  rst_n,
    fdmm_pix_if.sink   pix,
    input  wire logic [7:0] luma_thr,
    output logic       dist_valid,
    input  wire logic  dist_ready,
    output dist_t      dist_data
);

    logic       a_valid_reg;
    logic       a_ready;
    logic [7:0] dr_reg;
    logic [7:0] dg_reg;
    logic [7:0] db_reg;
    logic [7:0] cr_reg;
    logic [7:0] cg_reg;
    logic [7:0] cb_reg;
    logic       luma_ok_reg;

    logic       b_valid_reg;
    logic       b_ready;
    dist_t      b_data_reg;
    dist_t      b_data_next;

    logic [12:0] gray_sum;
    logic [7:0]  gray;
    logic [15:0] sq_r;
    logic [15:0] sq_g;
    logic [15:0] sq_b;

    // A stage may take new data when empty or when its contents move on
    assign b_ready   = !b_valid_reg || dist_ready;
    assign a_ready   = !a_valid_reg || b_ready;
    assign pix.ready = a_ready;

    // Gray value (11r + 16g + 5b) / 32 of the current pixel
    assign gray_sum = 13'd11 * {5'd0, pix.cur_red}
                    + {1'b0, pix.cur_green, 4'd0}
                    + 13'd5 * {5'd0, pix.cur_blue};
    assign gray = gray_sum[12:5];

    // Valid bits
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            a_valid_reg <= 1'b0;
            b_valid_reg <= 1'b0;
        end
        else
        begin
            if (a_ready)
                a_valid_reg <= pix.valid;
            if (b_ready)
                b_valid_reg <= a_valid_reg;
        end
    end

    // Capture differences and the luma decision
    always_ff @(posedge clk)
    begin
        if (a_ready)
        begin
            dr_reg      <= abs_diff8(pix.prev_red, pix.cur_red);
            dg_reg      <= abs_diff8(pix.prev_green, pix.cur_green);
            db_reg      <= abs_diff8(pix.prev_blue, pix.cur_blue);
            cr_reg      <= pix.cur_red;
            cg_reg      <= pix.cur_green;
            cb_reg      <= pix.cur_blue;
            luma_ok_reg <= (gray >= luma_thr);
        end
    end

    // Squares and their sum
    always_comb
    begin
        sq_r = {8'd0, dr_reg} * {8'd0, dr_reg};
        sq_g = {8'd0, dg_reg} * {8'd0, dg_reg};
        sq_b = {8'd0, db_reg} * {8'd0, db_reg};
        b_data_next.dist_sq   = {2'b00, sq_r} + {2'b00, sq_g} + {2'b00, sq_b};
        b_data_next.cur_red   = cr_reg;
        b_data_next.cur_green = cg_reg;
        b_data_next.cur_blue  = cb_reg;
        b_data_next.luma_ok   = luma_ok_reg;
    end

    always_ff @(posedge clk)
    begin
        if (b_ready)
            b_data_reg <= b_data_next;
    end

    assign dist_valid = b_valid_reg;
    assign dist_data  = b_data_reg;

endmodule

`default_nettype wire

>>> sv/fdmm_root.sv
// Root stages: floor(sqrt(dist/3)) one bit per step, four steps per stage.
// Depends on fdmm_pkg.
`default_nettype none

module fdmm_root
    import fdmm_pkg::*;
(
    input  wire logic  clk,
    input  wire logic  rst_n,
    input  wire logic  dist_valid,
    output logic       dist_ready,
    input  dist_t      dist_data,
    output logic       str_valid,
    input  wire logic  str_ready,
    output strength_t  str_data
);

    localparam int unsigned STEPS_PER_STAGE = 4;

    logic       c_valid_reg;
    logic       c_ready;
    root_t      c_root_reg;
    root_t      c_root_next;
    logic [7:0] c_cr_reg;
    logic [7:0] c_cg_reg;
    logic [7:0] c_cb_reg;
    logic       c_luma_reg;

    logic       d_valid_reg;
    logic       d_ready;
    root_t      d_root_next;
    strength_t  d_data_reg;

    assign d_ready    = !d_valid_reg || str_ready;
    assign c_ready    = !c_valid_reg || d_ready;
    assign dist_ready = c_ready;

    // Upper four root bits
    always_comb
    begin
        c_root_next.rem  = dist_data.dist_sq;
        c_root_next.root = 8'd0;
        for (int i = 0; i < STEPS_PER_STAGE; i++)
        begin
            c_root_next = root_step(c_root_next, 3'(7 - i));
        end
    end

    // Lower four root bits
    always_comb
    begin
        d_root_next = c_root_reg;
        for (int i = 0; i < STEPS_PER_STAGE; i++)
        begin
            d_root_next = root_step(d_root_next, 3'(3 - i));
        end
    end

    // Valid bits
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            c_valid_reg <= 1'b0;
            d_valid_reg <= 1'b0;
        end
        else
        begin
            if (c_ready)
                c_valid_reg <= dist_valid;
            if (d_ready)
                d_valid_reg <= c_valid_reg;
        end
    end

    // Advance payload
    always_ff @(posedge clk)
    begin
        if (c_ready)
        begin
            c_root_reg <= c_root_next;
            c_cr_reg   <= dist_data.cur_red;
            c_cg_reg   <= dist_data.cur_green;
            c_cb_reg   <= dist_data.cur_blue;
            c_luma_reg <= dist_data.luma_ok;
        end
        if (d_ready)
        begin
            d_data_reg.strength  <= d_root_next.root;
            d_data_reg.cur_red   <= c_cr_reg;
            d_data_reg.cur_green <= c_cg_reg;
            d_data_reg.cur_blue  <= c_cb_reg;
            d_data_reg.luma_ok   <= c_luma_reg;
        end
    end

    assign str_valid = d_valid_reg;
    assign str_data  = d_data_reg;

endmodule

`default_nettype wire

>>> sv/fdmm_out.sv
// Output stage: alpha thresholds, colour select, registered mask pixel.
// Depends on fdmm_pkg and fdmm_mask_if.
`default_nettype none

module fdmm_out
    import fdmm_pkg::*;
(
    input  wire logic  clk,
    input  wire logic  rst_n,
    input  cfg_t       cfg,
    input  wire logic  str_valid,
    output logic       str_ready,
    input  strength_t  str_data,
    fdmm_mask_if.source mask
);

    logic       e_valid_reg;
    logic       e_ready;
    logic [7:0] red_reg;
    logic [7:0] green_reg;
    logic [7:0] blue_reg;
    logic [7:0] alpha_reg;
    logic [7:0] red_next;
    logic [7:0] green_next;
    logic [7:0] blue_next;
    logic [7:0] alpha_next;
    logic       soft_mode;
    logic       normal;

    assign e_ready   = !e_valid_reg || mask.ready;
    assign str_ready = e_ready;

    // Decode mode and form the alpha
    always_comb
    begin
        soft_mode = (cfg.mode == MODE_SOFT_NORMAL) || (cfg.mode == MODE_SOFT_COLOR);
        normal    = (cfg.mode == MODE_HARD_NORMAL) || (cfg.mode == MODE_SOFT_NORMAL);
        if (str_data.strength < cfg.diff_thr)
            alpha_next = 8'd0;
        else if (soft_mode)
            alpha_next = str_data.strength;
        else
            alpha_next = ALPHA_FULL;
        if (!str_data.luma_ok)
            alpha_next = 8'd0;
        red_next   = normal ? str_data.cur_red   : cfg.tint_red;
        green_next = normal ? str_data.cur_green : cfg.tint_green;
        blue_next  = normal ? str_data.cur_blue  : cfg.tint_blue;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            e_valid_reg <= 1'b0;
        else if (e_ready)
            e_valid_reg <= str_valid;
    end

    // Hold the result until the sink takes it
    always_ff @(posedge clk)
    begin
        if (e_ready)
        begin
            red_reg   <= red_next;
            green_reg <= green_next;
            blue_reg  <= blue_next;
            alpha_reg <= alpha_next;
        end
    end

    assign mask.valid     = e_valid_reg;
    assign mask.out_red   = red_reg;
    assign mask.out_green = green_reg;
    assign mask.out_blue  = blue_reg;
    assign mask.out_alpha = alpha_reg;

endmodule

`default_nettype wire

>>> sv/frame_diff_motion_mask_pixel.sv
// Top level of the frame difference motion mask pixel block.
// Depends on fdmm_pkg, fdmm_if, fdmm_front, fdmm_root and fdmm_out.
//
//   channel | direction | handshake        | payload
//   pix     | in        | valid/ready      | prev_red/green/blue, cur_red/green/blue
//   mask    | out       | valid/ready      | out_red/green/blue, out_alpha
//   cfg     | in        | cfg_we only      | cfg_index, cfg_data
//
// Five register stages: differences and gray, squared distance, upper root
// bits, lower root bits, alpha and colour. One pixel per clock sustained
// while the sink is ready; each pixel passes through the stages in that
// order. Each stage holds under a stall and fills its own bubble, so nothing
// is lost or repeated. Reset clears valid bits and loads the register
// defaults; no clearing pass.
`default_nettype none

module frame_diff_motion_mask_pixel
    import fdmm_pkg::*;
(
    input  wire logic clk,
    input  wire logic rst_n,
    fdmm_pix_if.sink  pix,
    fdmm_mask_if.source mask,
    input  wire logic cfg_we,
    input  wire logic [CFG_IDX_W-1:0]  cfg_index,
    input  wire logic [CFG_DATA_W-1:0] cfg_data
);

    cfg_t      cfg_reg;
    logic      dist_valid;
    logic      dist_ready;
    dist_t     dist_data;
    logic      str_valid;
    logic      str_ready;
    strength_t str_data;

    // Configuration writes; unknown indexes drop
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.mode       <= MODE_HARD_COLOR;
            cfg_reg.diff_thr   <= 8'd31;
            cfg_reg.luma_thr   <= 8'd95;
            cfg_reg.tint_red   <= 8'd0;
            cfg_reg.tint_green <= 8'd255;
            cfg_reg.tint_blue  <= 8'd0;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                REG_MODE:       cfg_reg.mode       <= cfg_data[1:0];
                REG_DIFF_THR:   cfg_reg.diff_thr   <= cfg_data;
                REG_LUMA_THR:   cfg_reg.luma_thr   <= cfg_data;
                REG_TINT_RED:   cfg_reg.tint_red   <= cfg_data;
                REG_TINT_GREEN: cfg_reg.tint_green <= cfg_data;
                REG_TINT_BLUE:  cfg_reg.tint_blue  <= cfg_data;
                default:        cfg_reg            <= cfg_reg;
            endcase
        end
    end

    fdmm_front u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .pix        (pix),
        .luma_thr   (cfg_reg.luma_thr),
        .dist_valid (dist_valid),
        .dist_ready (dist_ready),
        .dist_data  (dist_data)
    );

    fdmm_root u_root (
        .clk        (clk),
        .rst_n      (rst_n),
        .dist_valid (dist_valid),
        .dist_ready (dist_ready),
        .dist_data  (dist_data),
        .str_valid  (str_valid),
        .str_ready  (str_ready),
        .str_data   (str_data)
    );

    fdmm_out u_out (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg        (cfg_reg),
        .str_valid  (str_valid),
        .str_ready  (str_ready),
        .str_data   (str_data),
        .mask       (mask)
    );

endmodule

`default_nettype wire

>>> tb/tb.sv
`timescale 1ns / 100ps
// Self-checking testbench for frame_diff_motion_mask_pixel: drives pixel pairs and
// register settings, checks every mask pixel against an in-bench model of the block.
// Depends on fdmm_pkg, fdmm_if and the RTL under sv/.

import fdmm_pkg::*;

typedef struct packed {
    logic [7:0] prev_red;
    logic [7:0] prev_green;
    logic [7:0] prev_blue;
    logic [7:0] cur_red;
    logic [7:0] cur_green;
    logic [7:0] cur_blue;
} pix_pair_t;

typedef struct packed {
    logic [7:0] out_red;
    logic [7:0] out_green;
    logic [7:0] out_blue;
    logic [7:0] out_alpha;
} mask_pix_t;

// Register copy, mask prediction and the queue of mask pixels still due
class motion_mask_scoreboard;
    logic [1:0]  mode;
    logic [7:0]  diff_thr;
    logic [7:0]  luma_thr;
    logic [7:0]  tint_red;
    logic [7:0]  tint_green;
    logic [7:0]  tint_blue;
    mask_pix_t   masks_due[$];
    int unsigned errors;

    function new();
        mode       = MODE_HARD_COLOR;
        diff_thr   = 8'd31;
        luma_thr   = 8'd95;
        tint_red   = 8'd0;
        tint_green = 8'd255;
        tint_blue  = 8'd0;
        errors     = 0;
    endfunction

    // Mirror a register write; unknown indexes change nothing
    function void write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
        case (idx)
            REG_MODE:       mode       = data[1:0];
            REG_DIFF_THR:   diff_thr   = data;
            REG_LUMA_THR:   luma_thr   = data;
            REG_TINT_RED:   tint_red   = data;
            REG_TINT_GREEN: tint_green = data;
            REG_TINT_BLUE:  tint_blue  = data;
            default: ;
        endcase
    endfunction

    // Largest k with 3*k*k <= dist_sq
    function logic [7:0] motion_strength(int unsigned dist_sq);
        int unsigned k;
        k = 0;
        while (k < 255 && 3 * (k + 1) * (k + 1) <= dist_sq)
            k++;
        return k[7:0];
    endfunction

    function mask_pix_t mask_of(pix_pair_t p);
        int unsigned dr;
        int unsigned dg;
        int unsigned db;
        int unsigned gray;
        logic [7:0]  strength;
        logic        soft_mode;
        logic        normal;
        mask_pix_t   m;
        dr = (p.prev_red > p.cur_red) ? p.prev_red - p.cur_red : p.cur_red - p.prev_red;
        dg = (p.prev_green > p.cur_green) ? p.prev_green - p.cur_green
                                          : p.cur_green - p.prev_green;
        db = (p.prev_blue > p.cur_blue) ? p.prev_blue - p.cur_blue
                                        : p.cur_blue - p.prev_blue;
        strength = motion_strength(dr * dr + dg * dg + db * db);
        soft_mode = (mode == MODE_SOFT_NORMAL) || (mode == MODE_SOFT_COLOR);
        normal    = (mode == MODE_HARD_NORMAL) || (mode == MODE_SOFT_NORMAL);
        if (strength < diff_thr)
            m.out_alpha = 8'd0;
        else
            m.out_alpha = soft_mode ? strength : ALPHA_FULL;
        gray = (11 * int'(p.cur_red) + 16 * int'(p.cur_green) + 5 * int'(p.cur_blue)) >> 5;
        if (gray < luma_thr)
            m.out_alpha = 8'd0;
        m.out_red   = normal ? p.cur_red   : tint_red;
        m.out_green = normal ? p.cur_green : tint_green;
        m.out_blue  = normal ? p.cur_blue  : tint_blue;
        return m;
    endfunction

    function void note_pixel(pix_pair_t p);
        masks_due.push_back(mask_of(p));
    endfunction

    function void flag_field(string name, logic [7:0] exp_v, logic [7:0] act_v);
        if (exp_v !== act_v)
        begin
            $display("%0t: %s mismatch, expected %0d actual %0d", $time, name, exp_v, act_v);
            errors++;
        end
    endfunction

    function void check_mask(mask_pix_t got);
        mask_pix_t want;
        if (masks_due.size() == 0)
        begin
            $display("%0t: mask pixel with none due, expected none actual %h", $time, got);
            errors++;
            return;
        end
        want = masks_due.pop_front();
        flag_field("out_red",   want.out_red,   got.out_red);
        flag_field("out_green", want.out_green, got.out_green);
        flag_field("out_blue",  want.out_blue,  got.out_blue);
        flag_field("out_alpha", want.out_alpha, got.out_alpha);
    endfunction

    function int pending();
        return masks_due.size();
    endfunction

    function void flag_leftover();
        if (masks_due.size() != 0)
        begin
            $display("%0t: %0d mask pixels never arrived, expected %h actual none",
                     $time, masks_due.size(), masks_due[0]);
            errors++;
        end
    endfunction
endclass

module tb;

    localparam int CLK_PERIOD    = 10;
    localparam int RESET_CYCLES  = 6;
    localparam int PIPE_LATENCY  = 5;
    localparam int CYCLE_LIMIT   = 200000;
    localparam int SETTING_COUNT = 12;
    localparam int PIX_PER_SET   = 125;

    // Indexes that name no register
    localparam logic [CFG_IDX_W-1:0] REG_UNUSED_A = 3'd6;
    localparam logic [CFG_IDX_W-1:0] REG_UNUSED_B = 3'd7;

    // Pixel mix for random traffic
    localparam int MIX_UNIFORM   = 0;
    localparam int MIX_NEAR      = 1;
    localparam int MIX_STILL     = 2;
    localparam int MIX_EXTREME   = 3;

    logic clk = 1'b0;
    logic rst_n;
    logic cfg_we;
    logic [CFG_IDX_W-1:0]  cfg_index;
    logic [CFG_DATA_W-1:0] cfg_data;

    int unsigned src_idle_pct;
    int unsigned snk_idle_pct;
    int unsigned cycle_count = 0;

    motion_mask_scoreboard sb = new();

    fdmm_pix_if  pix_ch();
    fdmm_mask_if mask_ch();

    frame_diff_motion_mask_pixel u_top (
        .clk       (clk),
        .rst_n     (rst_n),
        .pix       (pix_ch),
        .mask      (mask_ch),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    always #(CLK_PERIOD / 2) clk = ~clk;

    // Abort a hung run
    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("frame_diff_motion_mask_pixel verification failed");
            $finish;
        end
    end

    // Receive side: random back-pressure, check every transfer out
    initial
    begin
        mask_ch.ready = 1'b0;
        forever
        begin
            @(posedge clk);
            if (rst_n)
            begin
                if (mask_ch.valid && mask_ch.ready)
                    sb.check_mask({mask_ch.out_red, mask_ch.out_green,
                                   mask_ch.out_blue, mask_ch.out_alpha});
                mask_ch.ready <= ($urandom_range(99) >= snk_idle_pct);
            end
        end
    end

    function automatic logic [7:0] near_value(logic [7:0] base);
        int v;
        v = int'(base) + int'($urandom_range(80)) - 40;
        if (v < 0)
            v = 0;
        if (v > 255)
            v = 255;
        return v[7:0];
    endfunction

    function automatic logic [7:0] rail_value();
        return $urandom_range(1) ? 8'd255 : 8'd0;
    endfunction

    function automatic pix_pair_t random_pixel();
        pix_pair_t p;
        p = pix_pair_t'({$urandom, $urandom});
        case ($urandom_range(3))
            MIX_UNIFORM: ;
            MIX_NEAR:
            begin
                p.prev_red   = near_value(p.cur_red);
                p.prev_green = near_value(p.cur_green);
                p.prev_blue  = near_value(p.cur_blue);
            end
            MIX_STILL:
            begin
                p.prev_red   = p.cur_red;
                p.prev_green = p.cur_green;
                p.prev_blue  = p.cur_blue;
            end
            MIX_EXTREME:
                p = {rail_value(), rail_value(), rail_value(),
                     rail_value(), rail_value(), rail_value()};
            default: ;
        endcase
        return p;
    endfunction

    // Offer one pixel pair, with random gaps first; hold until it transfers
    task automatic send_pixel(input pix_pair_t p);
        while ($urandom_range(99) < src_idle_pct)
        begin
            pix_ch.valid <= 1'b0;
            @(posedge clk);
        end
        pix_ch.valid      <= 1'b1;
        pix_ch.prev_red   <= p.prev_red;
        pix_ch.prev_green <= p.prev_green;
        pix_ch.prev_blue  <= p.prev_blue;
        pix_ch.cur_red    <= p.cur_red;
        pix_ch.cur_green  <= p.cur_green;
        pix_ch.cur_blue   <= p.cur_blue;
        do
            @(posedge clk);
        while (!pix_ch.ready);
        sb.note_pixel(p);
    endtask

    // Stop sending and hold until every mask pixel has come back
    task automatic wait_drained();
        pix_ch.valid <= 1'b0;
        while (sb.pending() != 0)
            @(posedge clk);
    endtask

    task automatic write_cfg(input logic [CFG_IDX_W-1:0] idx,
                             input logic [CFG_DATA_W-1:0] data);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        sb.write_reg(idx, data);
        @(posedge clk);
    endtask

    initial
    begin
        pix_pair_t   directed[$];
        logic [1:0]  mode_sel;
        logic [7:0]  diff_sel;
        logic [7:0]  luma_sel;
        logic [7:0]  tint_r;
        logic [7:0]  tint_g;
        logic [7:0]  tint_b;

        rst_n             = 1'b0;
        cfg_we            = 1'b0;
        cfg_index         = '0;
        cfg_data          = '0;
        pix_ch.valid      = 1'b0;
        pix_ch.prev_red   = '0;
        pix_ch.prev_green = '0;
        pix_ch.prev_blue  = '0;
        pix_ch.cur_red    = '0;
        pix_ch.cur_green  = '0;
        pix_ch.cur_blue   = '0;
        src_idle_pct      = 7;
        snk_idle_pct      = 80;

        repeat (RESET_CYCLES) @(posedge clk);
        rst_n <= 1'b1;

        // Directed pixels under the reset settings
        directed.push_back({8'd0,   8'd0,   8'd0,   8'd0,   8'd0,   8'd0});
        directed.push_back({8'd0,   8'd0,   8'd0,   8'd255, 8'd255, 8'd255});
        directed.push_back({8'd255, 8'd255, 8'd255, 8'd0,   8'd0,   8'd0});
        // strength exactly at the difference threshold, and one below it
        directed.push_back({8'd64,  8'd64,  8'd64,  8'd95,  8'd95,  8'd95});
        directed.push_back({8'd65,  8'd65,  8'd65,  8'd95,  8'd95,  8'd95});
        // gray one below the luma threshold
        directed.push_back({8'd63,  8'd63,  8'd63,  8'd94,  8'd94,  8'd94});
        directed.push_back({8'd255, 8'd0,   8'd255, 8'd0,   8'd255, 8'd0});
        directed.push_back({8'd0,   8'd255, 8'd0,   8'd255, 8'd0,   8'd255});
        directed.push_back({8'd255, 8'd255, 8'd255, 8'd0,   8'd255, 8'd255});
        directed.push_back({8'd170, 8'd85,  8'd170, 8'd85,  8'd170, 8'd85});
        directed.push_back({8'd85,  8'd170, 8'd85,  8'd170, 8'd85,  8'd170});
        foreach (directed[i])
            send_pixel(directed[i]);

        // Random traffic over a run of settings, extremes among them
        for (int set = 0; set < SETTING_COUNT; set++)
        begin
            wait_drained();
            mode_sel = 2'(set % 4);
            diff_sel = (set == 0 || set == 6 || set == 11) ? 8'd0 :
                       (set == 1 || set == 5) ? 8'd255 : 8'($urandom_range(120));
            luma_sel = (set == 0 || set == 4) ? 8'd0 :
                       (set == 1 || set == 7) ? 8'd255 : 8'($urandom_range(160));
            tint_r   = (set == 2) ? 8'd0 : (set == 3) ? 8'd255 : 8'($urandom);
            tint_g   = (set == 2) ? 8'd0 : (set == 3) ? 8'd255 : 8'($urandom);
            tint_b   = (set == 2) ? 8'd0 : (set == 3) ? 8'd255 : 8'($urandom);
            // upper mode bits must be dropped by the block
            write_cfg(REG_MODE, {6'($urandom), mode_sel});
            write_cfg(REG_DIFF_THR, diff_sel);
            write_cfg(REG_LUMA_THR, luma_sel);
            write_cfg(REG_TINT_RED, tint_r);
            write_cfg(REG_TINT_GREEN, tint_g);
            write_cfg(REG_TINT_BLUE, tint_b);
            write_cfg(REG_UNUSED_A, 8'($urandom));
            write_cfg(REG_UNUSED_B, 8'($urandom));
            cfg_we <= 1'b0;

            if (set < SETTING_COUNT / 3)
            begin
                src_idle_pct = 7;
                snk_idle_pct = 80;
            end
            else if (set < 2 * SETTING_COUNT / 3)
            begin
                src_idle_pct = 80;
                snk_idle_pct = 7;
            end
            else
            begin
                src_idle_pct = 0;
                snk_idle_pct = 0;
            end

            repeat (PIX_PER_SET)
                send_pixel(random_pixel());
        end

        wait_drained();
        repeat (PIPE_LATENCY + 3) @(posedge clk);
        sb.flag_leftover();
        if (sb.errors == 0)
            $display("frame_diff_motion_mask_pixel verification clean");
        else
            $display("frame_diff_motion_mask_pixel verification failed");
        $finish;
    end

endmodule
